// ===== sv/xmt_pkg.sv =====
package xmt_pkg;

    localparam int OUT_W = 24;
    localparam int MAX_EV = 2;

    typedef enum logic [14:0] {
        M_TEXT       = 15'b000000000000001,
        M_OPEN       = 15'b000000000000010,
        M_SEARCH     = 15'b000000000000100,
        M_COMMENT    = 15'b000000000001000,
        M_DOCTYPE    = 15'b000000000010000,
        M_INST       = 15'b000000000100000,
        M_HALT       = 15'b000000001000000,
        M_TAG_NAME   = 15'b000000010000000,
        M_ATTR_START = 15'b000000100000000,
        M_ATTR_NAME  = 15'b000001000000000,
        M_SEEK_EQ    = 15'b000010000000000,
        M_SEEK_VAL   = 15'b000100000000000,
        M_QVAL       = 15'b001000000000000,
        M_UVAL       = 15'b010000000000000,
        M_TAG_END    = 15'b100000000000000
    } t_mode;

    localparam logic [2:0] EV_CONTENT = 3'd0;
    localparam logic [2:0] EV_START   = 3'd1;
    localparam logic [2:0] EV_END     = 3'd2;
    localparam logic [2:0] EV_ATTR    = 3'd3;
    localparam logic [2:0] EV_ERROR   = 3'd4;

    localparam logic [1:0] SK_CONTENT = 2'd0;
    localparam logic [1:0] SK_START   = 2'd1;
    localparam logic [1:0] SK_END     = 2'd2;

    localparam logic [1:0] Q_NONE   = 2'd0;
    localparam logic [1:0] Q_SINGLE = 2'd1;
    localparam logic [1:0] Q_DOUBLE = 2'd2;

    localparam logic [2:0] KW_NONE = 3'd7;
    localparam logic [2:0] KW_LAST = 3'd6;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_D     = 8'h44;

    localparam logic [7:0] KW_DOCTYPE [0:6] = '{8'h44, 8'h4F, 8'h43, 8'h54, 8'h59, 8'h50, 8'h45};

    typedef struct packed {
        logic [2:0]       kind;
        logic [OUT_W-1:0] ts;
        logic [OUT_W-1:0] te;
        logic [OUT_W-1:0] vs;
        logic [OUT_W-1:0] ve;
        logic             hv;
        logic             sc;
        logic             last;
    } t_event;

    function automatic logic is_sp(input logic [7:0] c);
        return (c == CH_SP) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_quote(input logic [7:0] c);
        return (c == CH_SQ) || (c == CH_DQ);
    endfunction

endpackage

// ===== sv/xml_markup_tokenizer.sv =====
// Byte-serial XML tokenizer: one document byte is taken per cycle while the result queue has
// room, and turned into zero, one or two token events (content, start tag, end tag, attribute,
// malformed-opener error), each carrying 24-bit byte offsets. Events leave through a four-entry
// result queue one per cycle while the receiver is ready; input is accepted whenever the queue
// has room for two events.
module xml_markup_tokenizer #(
    parameter int POS_WIDTH = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_event_kind,
    output logic [23:0] o_text_start,
    output logic [23:0] o_text_end,
    output logic [23:0] o_val_start,
    output logic [23:0] o_val_end,
    output logic        o_has_value,
    output logic        o_self_closing,
    output logic        o_last_event
);
    import xmt_pkg::*;

    t_event     ev0, ev1;
    logic [1:0] ev_cnt;
    logic       accept, pop;

    t_event     r_q [0:3];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt;

    assign o_ready = (r_cnt <= 3'd2);
    assign accept  = i_valid && o_ready;
    assign o_valid = (r_cnt != 3'd0);
    assign pop     = o_valid && i_ready;

    xmt_core #(.POS_WIDTH(POS_WIDTH)) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_data_byte(i_data_byte),
        .i_last_byte(i_last_byte),
        .o_ev0      (ev0),
        .o_ev1      (ev1),
        .o_count    (ev_cnt)
    );

    always_ff @(posedge i_clk) begin
        if (accept && ev_cnt != 2'd0) r_q[r_wr] <= ev0;
        if (accept && ev_cnt == 2'd2) r_q[r_wr + 2'd1] <= ev1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (accept) r_wr <= r_wr + ev_cnt;
            if (pop) r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + (accept ? {1'b0, ev_cnt} : 3'd0) - (pop ? 3'd1 : 3'd0);
        end
    end

    assign o_event_kind   = r_q[r_rd].kind;
    assign o_text_start   = r_q[r_rd].ts;
    assign o_text_end     = r_q[r_rd].te;
    assign o_val_start    = r_q[r_rd].vs;
    assign o_val_end      = r_q[r_rd].ve;
    assign o_has_value    = r_q[r_rd].hv;
    assign o_self_closing = r_q[r_rd].sc;
    assign o_last_event   = r_q[r_rd].last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 3'd4)
        else $error("result queue overflow");
    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("pending item lost");
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept && !pop |=> $stable(r_cnt))
        else $error("queue count moved while idle");

endmodule

// ===== sv/xmt_core.sv =====
module xmt_core #(
    parameter int POS_WIDTH = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    output xmt_pkg::t_event     o_ev0,
    output xmt_pkg::t_event     o_ev1,
    output logic [1:0]          o_count
);
    import xmt_pkg::*;

    localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

    t_mode                r_mode, n_mode;
    logic [POS_WIDTH-1:0] r_pos, n_pos;
    logic                 r_so, n_so;
    logic [POS_WIDTH-1:0] r_ss, n_ss;
    logic [POS_WIDTH-1:0] r_se, n_se;
    logic [1:0]           r_sk, n_sk;
    logic                 r_tf, n_tf;
    logic                 r_ao, n_ao;
    logic [POS_WIDTH-1:0] r_ans, n_ans;
    logic [POS_WIDTH-1:0] r_ane, n_ane;
    logic [POS_WIDTH-1:0] r_avs, n_avs;
    logic                 r_vb, n_vb;
    logic [1:0]           r_qk, n_qk;
    logic [15:0]          r_prev, n_prev;
    logic [2:0]           r_kw, n_kw;

    t_event ev0, ev1;
    logic [1:0] cnt;

    function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] p);
        return (p == POS_MAX) ? p : p + POS_WIDTH'(1);
    endfunction

    function automatic t_event mk_ev(input logic [2:0] kind,
                                     input logic [POS_WIDTH-1:0] ts,
                                     input logic [POS_WIDTH-1:0] te,
                                     input logic [POS_WIDTH-1:0] vs,
                                     input logic [POS_WIDTH-1:0] ve,
                                     input logic hv, input logic sc);
        t_event e;
        e.kind = kind;
        e.ts = OUT_W'(ts);
        e.te = OUT_W'(te);
        e.vs = OUT_W'(vs);
        e.ve = OUT_W'(ve);
        e.hv = hv;
        e.sc = sc;
        e.last = 1'b0;
        return e;
    endfunction

    always_comb begin
        logic [7:0] ch;
        logic crlf, run_tag, done, doc, dash, closing;
        t_event e;
        logic emit;
        ch = i_data_byte;
        crlf = (ch == CH_CR) || (ch == CH_LF);
        run_tag = 1'b0;
        done = 1'b0;
        doc = 1'b0;
        dash = 1'b0;
        closing = 1'b0;
        e = '0;
        emit = 1'b0;
        ev0 = '0;
        ev1 = '0;
        cnt = 2'd0;
        n_mode = r_mode; n_pos = r_pos; n_so = r_so; n_ss = r_ss; n_se = r_se;
        n_sk = r_sk; n_tf = r_tf; n_ao = r_ao; n_ans = r_ans; n_ane = r_ane;
        n_avs = r_avs; n_vb = r_vb; n_qk = r_qk; n_prev = r_prev; n_kw = r_kw;

        unique case (r_mode)
            M_TEXT: begin
                if (!crlf) begin
                    if (ch == CH_LT) begin
                        n_mode = M_OPEN;
                    end else begin
                        if (!n_so) begin
                            n_so = 1'b1; n_ss = r_pos; n_sk = SK_CONTENT;
                        end
                        n_se = sat_inc(r_pos);
                    end
                end
            end
            M_OPEN: begin
                if (!crlf) begin
                    if (ch == CH_SLASH || is_alpha(ch) || ch == CH_BANG || ch == CH_QUEST) begin
                        if (n_so && n_se != n_ss) begin
                            ev0 = mk_ev(3'(n_sk), n_ss, n_se, '0, '0, 1'b0, n_tf);
                            cnt = 2'd1;
                        end
                        n_so = 1'b0; n_sk = SK_CONTENT; n_tf = 1'b0;
                        if (ch == CH_BANG) begin
                            n_mode = M_SEARCH; n_kw = '0;
                        end else if (ch == CH_QUEST) begin
                            n_mode = M_INST;
                        end else begin
                            n_mode = M_TAG_NAME; run_tag = 1'b1;
                        end
                    end else begin
                        ev0 = mk_ev(EV_ERROR, r_pos, r_pos, '0, '0, 1'b0, 1'b0);
                        cnt = 2'd1;
                        n_mode = M_HALT;
                    end
                end
            end
            M_SEARCH: begin
                if (crlf) begin
                    if (r_so) n_kw = KW_NONE;
                end else if (ch == CH_DASH || is_alpha(ch)) begin
                    if (!r_so) begin
                        n_so = 1'b1; n_ss = r_pos; n_se = r_pos;
                        n_kw = (ch == CH_D) ? 3'd1 : KW_NONE;
                    end else begin
                        doc = (r_kw == KW_LAST) && (ch == CH_E);
                        n_se = r_pos;
                        if (r_kw < KW_LAST && ch == KW_DOCTYPE[r_kw]) n_kw = r_kw + 3'd1;
                        else n_kw = KW_NONE;
                        dash = (r_pos - r_ss == POS_WIDTH'(1)) && r_prev[7:0] == CH_DASH
                            && ch == CH_DASH;
                        if (dash) begin
                            n_so = 1'b0; n_mode = M_COMMENT;
                        end else if (doc) begin
                            n_so = 1'b0; n_mode = M_DOCTYPE;
                        end
                    end
                end else begin
                    n_mode = M_TAG_NAME; run_tag = 1'b1;
                end
            end
            M_COMMENT: begin
                if (ch == CH_GT && r_prev[7:0] == CH_DASH && r_prev[15:8] == CH_DASH)
                    n_mode = M_TEXT;
            end
            M_DOCTYPE: begin
                if (ch == CH_GT) n_mode = M_TEXT;
            end
            M_INST: begin
                if (ch == CH_GT && r_prev[7:0] == CH_QUEST) n_mode = M_TEXT;
            end
            M_HALT: begin
            end
            default: run_tag = 1'b1;
        endcase

        if (run_tag) begin
            for (int g = 0; g < 8; g++) begin
                emit = 1'b0;
                if (!done) begin
                    unique case (n_mode)
                        M_TAG_NAME: begin
                            if (ch == CH_SLASH) begin
                                n_sk = SK_END;
                                if (!n_so) begin
                                    n_so = 1'b1; n_ss = sat_inc(r_pos);
                                end
                                done = 1'b1;
                            end else if (ch == CH_GT || is_sp(ch)) begin
                                n_se = r_pos; n_mode = M_ATTR_START;
                            end else begin
                                if (!n_so) begin
                                    n_sk = SK_START; n_so = 1'b1; n_ss = r_pos;
                                end
                                done = 1'b1;
                            end
                        end
                        M_ATTR_START: begin
                            if (is_sp(ch) || is_quote(ch)) begin
                                done = 1'b1;
                            end else if (ch == CH_SLASH) begin
                                n_tf = 1'b1; done = 1'b1;
                            end else if (ch == CH_GT) begin
                                n_mode = M_TAG_END;
                            end else begin
                                n_ao = 1'b0; n_mode = M_ATTR_NAME;
                            end
                        end
                        M_ATTR_NAME: begin
                            if (!n_ao) begin
                                n_ao = 1'b1; n_ans = r_pos; n_avs = '0; n_vb = 1'b0;
                            end
                            if (is_sp(ch) || ch == CH_EQ || ch == CH_SLASH || ch == CH_GT) begin
                                n_ane = r_pos; n_mode = M_SEEK_EQ;
                            end else begin
                                done = 1'b1;
                            end
                        end
                        M_SEEK_EQ: begin
                            if (is_sp(ch) || ch == CH_SLASH || is_quote(ch)) begin
                                done = 1'b1;
                            end else if (ch == CH_EQ) begin
                                n_mode = M_SEEK_VAL; done = 1'b1;
                            end else begin
                                e = mk_ev(EV_ATTR, n_ans, n_ane, '0, '0, 1'b0, 1'b0);
                                emit = 1'b1;
                                n_ao = 1'b0; n_mode = M_ATTR_START;
                            end
                        end
                        M_SEEK_VAL: begin
                            if (is_sp(ch)) begin
                                done = 1'b1;
                            end else if (is_quote(ch)) begin
                                n_qk = (ch == CH_SQ) ? Q_SINGLE : Q_DOUBLE;
                                n_mode = M_QVAL; done = 1'b1;
                            end else begin
                                n_mode = M_UVAL;
                            end
                        end
                        M_QVAL, M_UVAL: begin
                            if (n_mode == M_QVAL)
                                closing = (ch == CH_SQ && n_qk == Q_SINGLE)
                                    || (ch == CH_DQ && n_qk == Q_DOUBLE);
                            else
                                closing = is_sp(ch) || ch == CH_GT || ch == CH_SLASH;
                            if (!n_vb) begin
                                n_vb = 1'b1; n_avs = r_pos;
                            end
                            if (closing) begin
                                e = mk_ev(EV_ATTR, n_ans, n_ane, n_avs, r_pos, 1'b1, 1'b0);
                                emit = 1'b1;
                                n_ao = 1'b0; n_qk = Q_NONE; n_mode = M_ATTR_START;
                            end else begin
                                done = 1'b1;
                            end
                        end
                        M_TAG_END: begin
                            if (n_so && n_se != n_ss) begin
                                e = mk_ev(3'(n_sk), n_ss, n_se, '0, '0, 1'b0, n_tf);
                                emit = 1'b1;
                            end
                            n_so = 1'b0; n_sk = SK_CONTENT; n_tf = 1'b0;
                            n_mode = M_TEXT; done = 1'b1;
                        end
                        default: begin
                            n_mode = M_TEXT; done = 1'b1;
                        end
                    endcase
                    if (emit) begin
                        if (cnt == 2'd0) begin
                            ev0 = e; cnt = 2'd1;
                        end else if (cnt == 2'd1) begin
                            ev1 = e; cnt = 2'd2;
                        end
                    end
                end
            end
        end

        if (cnt == 2'd1) ev0.last = 1'b1;
        if (cnt == 2'd2) ev1.last = 1'b1;

        n_prev = {r_prev[7:0], ch};
        n_pos = sat_inc(r_pos);
        if (i_last_byte) begin
            n_mode = M_TEXT; n_pos = '0; n_so = 1'b0; n_ss = '0; n_se = '0;
            n_sk = SK_CONTENT; n_tf = 1'b0; n_ao = 1'b0; n_ans = '0; n_ane = '0;
            n_avs = '0; n_vb = 1'b0; n_qk = Q_NONE; n_prev = '0; n_kw = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_TEXT; r_pos <= '0; r_so <= 1'b0; r_ss <= '0; r_se <= '0;
            r_sk <= SK_CONTENT; r_tf <= 1'b0; r_ao <= 1'b0; r_ans <= '0; r_ane <= '0;
            r_avs <= '0; r_vb <= 1'b0; r_qk <= Q_NONE; r_prev <= '0; r_kw <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode; r_pos <= n_pos; r_so <= n_so; r_ss <= n_ss; r_se <= n_se;
            r_sk <= n_sk; r_tf <= n_tf; r_ao <= n_ao; r_ans <= n_ans; r_ane <= n_ane;
            r_avs <= n_avs; r_vb <= n_vb; r_qk <= n_qk; r_prev <= n_prev; r_kw <= n_kw;
        end
    end

    assign o_ev0 = ev0;
    assign o_ev1 = ev1;
    assign o_count = cnt;

endmodule

// ===== tb/tb.sv =====
module tb;
    import xmt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        string  txt;
        bit     typed;
        t_event ev;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_event_kind;
    logic [23:0] o_text_start;
    logic [23:0] o_text_end;
    logic [23:0] o_val_start;
    logic [23:0] o_val_end;
    logic        o_has_value;
    logic        o_self_closing;
    logic        o_last_event;

    xml_markup_tokenizer dut (.*);

    // tokenizer state mirror
    t_mode       tok_mode;
    logic [23:0] tok_pos;
    logic        span_on;
    logic [23:0] span_lo;
    logic [23:0] span_hi;
    logic [1:0]  span_kd;
    logic        flat;
    logic        attr_on;
    logic [23:0] an_lo;
    logic [23:0] an_hi;
    logic [23:0] av_lo;
    logic        val_seen;
    logic [1:0]  quote;
    logic [15:0] prev2;
    logic [2:0]  kw_len;

    t_event step_ev [2];
    int     step_n;
    t_event pending_events [$];

    int  fails = 0;
    int  quiet = 0;
    int  stall = 0;
    bit  idle_on = 1;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SP || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_q(logic [7:0] c);
        return c == CH_SQ || c == CH_DQ;
    endfunction

    function automatic logic [23:0] pos_inc(logic [23:0] p);
        return (p == 24'hFFFFFF) ? p : p + 24'd1;
    endfunction

    function automatic void clear_tokens();
        tok_mode = M_TEXT;
        tok_pos = '0;
        span_on = 1'b0;
        span_lo = '0;
        span_hi = '0;
        span_kd = SK_CONTENT;
        flat = 1'b0;
        attr_on = 1'b0;
        an_lo = '0;
        an_hi = '0;
        av_lo = '0;
        val_seen = 1'b0;
        quote = Q_NONE;
        prev2 = '0;
        kw_len = '0;
    endfunction

    function automatic void add_event(logic [2:0] k, logic [23:0] ts, logic [23:0] te,
                                      logic [23:0] vs, logic [23:0] ve, logic hv, logic sc);
        if (step_n < MAX_EV) begin
            step_ev[step_n] = '{k, ts, te, vs, ve, hv, sc, 1'b0};
            step_n++;
        end
    endfunction

    function automatic void close_span();
        if (span_on && span_hi != span_lo)
            add_event({1'b0, span_kd}, span_lo, span_hi, '0, '0, 1'b0, flat);
        span_on = 1'b0;
        span_kd = SK_CONTENT;
        flat = 1'b0;
    endfunction

    function automatic void close_attr(logic hv, logic [23:0] vend);
        add_event(EV_ATTR, an_lo, an_hi, hv ? av_lo : 24'd0, hv ? vend : 24'd0, hv, 1'b0);
        attr_on = 1'b0;
    endfunction

    function automatic void tag_step(logic [7:0] ch, logic [23:0] pos);
        bit closing;
        for (int g = 0; g < 8; g++) begin
            case (tok_mode)
                M_TAG_NAME: begin
                    if (ch == CH_SLASH) begin
                        span_kd = SK_END;
                        if (!span_on) begin
                            span_on = 1'b1;
                            span_lo = pos_inc(pos);
                        end
                        return;
                    end
                    if (ch == CH_GT || is_blank(ch)) begin
                        span_hi = pos;
                        tok_mode = M_ATTR_START;
                        continue;
                    end
                    if (!span_on) begin
                        span_kd = SK_START;
                        span_on = 1'b1;
                        span_lo = pos;
                    end
                    return;
                end
                M_ATTR_START: begin
                    if (is_blank(ch) || is_q(ch)) return;
                    if (ch == CH_SLASH) begin
                        flat = 1'b1;
                        return;
                    end
                    if (ch == CH_GT) begin
                        tok_mode = M_TAG_END;
                        continue;
                    end
                    attr_on = 1'b0;
                    tok_mode = M_ATTR_NAME;
                end
                M_ATTR_NAME: begin
                    if (!attr_on) begin
                        attr_on = 1'b1;
                        an_lo = pos;
                        av_lo = '0;
                        val_seen = 1'b0;
                    end
                    if (is_blank(ch) || ch == CH_EQ || ch == CH_SLASH || ch == CH_GT) begin
                        an_hi = pos;
                        tok_mode = M_SEEK_EQ;
                        continue;
                    end
                    return;
                end
                M_SEEK_EQ: begin
                    if (is_blank(ch) || ch == CH_SLASH || is_q(ch)) return;
                    if (ch == CH_EQ) begin
                        tok_mode = M_SEEK_VAL;
                        return;
                    end
                    close_attr(1'b0, '0);
                    tok_mode = M_ATTR_START;
                end
                M_SEEK_VAL: begin
                    if (is_blank(ch)) return;
                    if (is_q(ch)) begin
                        quote = (ch == CH_SQ) ? Q_SINGLE : Q_DOUBLE;
                        tok_mode = M_QVAL;
                        return;
                    end
                    tok_mode = M_UVAL;
                end
                M_QVAL, M_UVAL: begin
                    if (tok_mode == M_QVAL)
                        closing = (ch == CH_SQ && quote == Q_SINGLE) ||
                                  (ch == CH_DQ && quote == Q_DOUBLE);
                    else
                        closing = is_blank(ch) || ch == CH_GT || ch == CH_SLASH;
                    if (!val_seen) begin
                        val_seen = 1'b1;
                        av_lo = pos;
                    end
                    if (!closing) return;
                    close_attr(1'b1, pos);
                    quote = Q_NONE;
                    tok_mode = M_ATTR_START;
                end
                M_TAG_END: begin
                    close_span();
                    tok_mode = M_TEXT;
                    return;
                end
                default: begin
                    tok_mode = M_TEXT;
                    return;
                end
            endcase
        end
    endfunction

    function automatic void tokenize_byte(logic [7:0] ch, logic last);
        logic [23:0] pos;
        bit crlf;
        bit doc;
        bit dash;
        pos = tok_pos;
        crlf = (ch == CH_CR || ch == CH_LF);
        step_n = 0;
        case (tok_mode)
            M_TEXT: begin
                if (!crlf) begin
                    if (ch == CH_LT) begin
                        tok_mode = M_OPEN;
                    end else begin
                        if (!span_on) begin
                            span_on = 1'b1;
                            span_lo = pos;
                            span_kd = SK_CONTENT;
                        end
                        span_hi = pos_inc(pos);
                    end
                end
            end
            M_OPEN: begin
                if (!crlf) begin
                    if (ch == CH_SLASH || is_letter(ch)) begin
                        close_span();
                        tok_mode = M_TAG_NAME;
                        tag_step(ch, pos);
                    end else if (ch == CH_BANG) begin
                        close_span();
                        tok_mode = M_SEARCH;
                        kw_len = '0;
                    end else if (ch == CH_QUEST) begin
                        close_span();
                        tok_mode = M_INST;
                    end else begin
                        add_event(EV_ERROR, pos, pos, '0, '0, 1'b0, 1'b0);
                        tok_mode = M_HALT;
                    end
                end
            end
            M_SEARCH: begin
                if (crlf) begin
                    if (span_on) kw_len = KW_NONE;
                end else if (ch == CH_DASH || is_letter(ch)) begin
                    if (!span_on) begin
                        span_on = 1'b1;
                        span_lo = pos;
                        span_hi = pos;
                        kw_len = (ch == CH_D) ? 3'd1 : KW_NONE;
                    end else begin
                        doc = (kw_len == KW_LAST && ch == CH_E);
                        span_hi = pos;
                        if (kw_len < KW_LAST && ch == KW_DOCTYPE[kw_len]) kw_len++;
                        else kw_len = KW_NONE;
                        dash = (span_hi - span_lo == 24'd1) && prev2[7:0] == CH_DASH &&
                               ch == CH_DASH;
                        if (dash) begin
                            span_on = 1'b0;
                            tok_mode = M_COMMENT;
                        end else if (doc) begin
                            span_on = 1'b0;
                            tok_mode = M_DOCTYPE;
                        end
                    end
                end else begin
                    tok_mode = M_TAG_NAME;
                    tag_step(ch, pos);
                end
            end
            M_COMMENT:
                if (ch == CH_GT && prev2 == {CH_DASH, CH_DASH}) tok_mode = M_TEXT;
            M_DOCTYPE:
                if (ch == CH_GT) tok_mode = M_TEXT;
            M_INST:
                if (ch == CH_GT && prev2[7:0] == CH_QUEST) tok_mode = M_TEXT;
            M_HALT: ;
            default: tag_step(ch, pos);
        endcase
        prev2 = {prev2[7:0], ch};
        tok_pos = pos_inc(pos);
        if (step_n > 0) step_ev[step_n - 1].last = 1'b1;
        if (last) clear_tokens();
    endfunction

    task automatic send_byte(logic [7:0] d, logic l, bit typed, t_event ev);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= d;
        i_last_byte <= l;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        tokenize_byte(d, l);
        if (typed) begin
            pending_events.push_back(ev);
        end else begin
            for (int k = 0; k < step_n; k++) pending_events.push_back(step_ev[k]);
        end
    endtask

    task automatic send_doc(logic [7:0] doc [$]);
        t_event none;
        none = '0;
        foreach (doc[k]) send_byte(doc[k], k == doc.size() - 1, 1'b0, none);
    endtask

    function automatic logic [7:0] any_letter();
        logic [7:0] c;
        c = 8'("a" + $urandom_range(0, 25));
        return $urandom_range(0, 1) ? c : c - 8'h20;
    endfunction

    function automatic void put_str(ref logic [7:0] q [$], input string s);
        for (int k = 0; k < s.len(); k++) q.push_back(s[k]);
    endfunction

    function automatic void put_name(ref logic [7:0] q [$]);
        int n;
        n = $urandom_range(1, 3);
        repeat (n) q.push_back(any_letter());
        if ($urandom_range(0, 9) == 0) q.push_back(CH_SLASH);
    endfunction

    function automatic void put_tag(ref logic [7:0] q [$]);
        int na;
        logic [7:0] qc;
        q.push_back(CH_LT);
        put_name(q);
        na = $urandom_range(0, 3);
        repeat (na) begin
            q.push_back($urandom_range(0, 5) == 0 ? CH_LF : CH_SP);
            if ($urandom_range(0, 9) != 0) put_name(q);
            case ($urandom_range(0, 4))
                0: ;
                1: begin
                    q.push_back(CH_EQ);
                    repeat ($urandom_range(1, 3)) q.push_back(any_letter());
                end
                2: begin
                    q.push_back(CH_EQ);
                    q.push_back(CH_SP);
                    q.push_back(any_letter());
                end
                default: begin
                    qc = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
                    q.push_back(CH_EQ);
                    q.push_back(qc);
                    repeat ($urandom_range(0, 3))
                        q.push_back($urandom_range(0, 3) == 0 ? (qc ^ 8'h05) : any_letter());
                    q.push_back(qc);
                end
            endcase
        end
        if ($urandom_range(0, 2) == 0) q.push_back(CH_SLASH);
        q.push_back(CH_GT);
    endfunction

    function automatic void make_doc(ref logic [7:0] q [$]);
        int nf;
        nf = $urandom_range(2, 8);
        repeat (nf) begin
            case ($urandom_range(0, 11))
                0, 1: repeat ($urandom_range(1, 5))
                    case ($urandom_range(0, 5))
                        0: q.push_back(CH_SP);
                        1: q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
                        2: q.push_back(8'($urandom_range(0, 255)) & ~8'h40 | 8'h80);
                        default: q.push_back(any_letter());
                    endcase
                2, 3, 4: put_tag(q);
                5: begin
                    put_str(q, "</");
                    put_name(q);
                    q.push_back(CH_GT);
                end
                6: put_str(q, $urandom_range(0, 1) ? "<!-- x-y -->" : "<!---->");
                7: put_str(q, $urandom_range(0, 2) ? "<!DOCTYPE r>" : "<!DOCTYP\nE>");
                8: put_str(q, $urandom_range(0, 1) ? "<?pi a?>" : "<\n?x ? ?>");
                9: put_str(q, $urandom_range(0, 1) ? "<!el x>" : "<!-a>");
                10: begin
                    q.push_back(CH_LT);
                    q.push_back(8'($urandom_range(0, 255)));
                end
                default: repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    task automatic check_field(string name, logic [23:0] exp_v, logic [23:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t %s expected %0h actual %0h", $time, name, exp_v, act_v);
            fails++;
        end
    endtask

    // result side: checking, stalls and watchdog
    always @(posedge i_clk) begin
        t_event ev;
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet = 0;
            else quiet++;
            if (quiet >= 2000) begin
                $display("Mismatches found");
                $finish;
            end
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_events.size() == 0) begin
                $display("%0t unexpected event kind %0h", $time, o_event_kind);
                fails++;
            end else begin
                ev = pending_events.pop_front();
                check_field("event_kind", 24'(ev.kind), 24'(o_event_kind));
                check_field("text_start", ev.ts, o_text_start);
                check_field("text_end", ev.te, o_text_end);
                check_field("val_start", ev.vs, o_val_start);
                check_field("val_end", ev.ve, o_val_end);
                check_field("has_value", 24'(ev.hv), 24'(o_has_value));
                check_field("self_closing", 24'(ev.sc), 24'(o_self_closing));
                check_field("last_event", 24'(ev.last), 24'(o_last_event));
            end
            stall = idle_on ? $urandom_range(0, 4) : 0;
        end
        if (stall > 0) begin
            i_ready <= 1'b0;
            stall--;
        end else begin
            i_ready <= 1'b1;
        end
    end

    initial begin
        t_row rows [4];
        logic [7:0] doc [$];
        int sent;
        rows[0] = '{"<1", 1, '{EV_ERROR, 24'd1, 24'd1, 24'd0, 24'd0, 1'b0, 1'b0, 1'b1}};
        rows[1] = '{"q<a b='v' c/>", 0, '0};
        rows[2] = '{"<!----><?x?>", 0, '0};
        rows[3] = '{"</b>", 0, '0};
        clear_tokens();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data_byte = '0;
        i_last_byte = 1'b0;
        i_ready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[r])
            for (int k = 0; k < rows[r].txt.len(); k++)
                send_byte(rows[r].txt[k], k == rows[r].txt.len() - 1,
                          rows[r].typed && k == rows[r].txt.len() - 1, rows[r].ev);
        sent = 0;
        while (sent < 1800) begin
            doc.delete();
            make_doc(doc);
            idle_on = $urandom_range(0, 3) != 0;
            send_doc(doc);
            sent += doc.size();
        end
        i_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (fails == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
